FILE: hdl/signed_dword_type_converter_top_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the signed dword type converter
// property checks on clock, disabled during reset
// ---------------------------------------------------------------------------
`ifndef SIGNED_DWORD_TYPE_CONVERTER_TOP_ASSERT_SVH
`define SIGNED_DWORD_TYPE_CONVERTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SDTC_ASSERT_IMP(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed");

`define SDTC_ASSERT_NXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("assertion failed");

`else

`define SDTC_ASSERT_IMP(lbl, a, b)
`define SDTC_ASSERT_NXT(lbl, a, b)

`endif

`endif

FILE: hdl/sdtc_pkg.sv
// ---------------------------------------------------------------------------
// sdtc_pkg
// types and constants of the signed dword type converter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdtc_pkg;

   typedef enum logic [3:0] {
      OP_BOOL  = 4'd0,
      OP_BYTE  = 4'd1,
      OP_WORD  = 4'd2,
      OP_DWORD = 4'd3,
      OP_SINT  = 4'd4,
      OP_USINT = 4'd5,
      OP_INT   = 4'd6,
      OP_UINT  = 4'd7,
      OP_UDINT = 4'd8,
      OP_LINT  = 4'd9,
      OP_TIME  = 4'd10,
      OP_BCD2  = 4'd11,
      OP_BCD4  = 4'd12,
      OP_BCD8  = 4'd13,
      OP_REAL  = 4'd14,
      OP_LREAL = 4'd15
   } op_type;

   localparam logic signed [31:0] EXACT_LIMIT = 32'sd16777216;
   localparam logic [31:0] BCD2_LIMIT = 32'd99;
   localparam logic [31:0] BCD4_LIMIT = 32'd9999;
   localparam logic [31:0] BCD8_LIMIT = 32'd99999999;
   // ceil(2^45 / 10000), exact quotient for values below 2^27
   localparam logic [31:0] DIV10K_MUL = 32'd3518437209;
   localparam int unsigned DIV10K_SHIFT = 45;

   typedef struct packed {
      logic [31:0] single_bits;
      logic [63:0] double_bits;
   } flt_type;

endpackage

`default_nettype wire

FILE: hdl/sdtc_req_if.sv
// ---------------------------------------------------------------------------
// sdtc_req_if
// input channel: opcode and signed source value
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdtc_req_if;
   logic              valid;
   logic              ready;
   logic [3:0]        op;
   logic signed [31:0] value;
   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

FILE: hdl/sdtc_rsp_if.sv
// ---------------------------------------------------------------------------
// sdtc_rsp_if
// result channel: converted pattern and enable-out flag
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result;
   logic        eno;
   modport source (output valid, output result, output eno, input ready);
   modport sink (input valid, input result, input eno, output ready);
endinterface

`default_nettype wire

FILE: hdl/signed_dword_type_converter_top.sv
// ---------------------------------------------------------------------------
// signed_dword_type_converter_top
// converts a signed 32-bit value to the bit pattern of a selected type
// ---------------------------------------------------------------------------
// usage
//  req carries op and value, rsp carries result and eno; valid/ready on each
//  one item enters per cycle while rsp is not stalled; a result is valid on
//  rsp once its item reaches the stage 4 register, in order; sustained
//  throughput one item per cycle while rsp is not stalled
//  the pipe depth is set by the bcd digit split: a reciprocal multiply for the
//  upper four digits, a remainder step, then the per-digit split
//  the four pipeline stages advance together; when rsp is stalled with a
//  result waiting, the whole pipe holds and req.ready drops
//  eno is a held flag: the real conversion sets it when the magnitude is
//  at most 2^24 and clears it otherwise; other ops leave it, and every
//  result reports its value as of that item
//  reset clears the flag and all stage valid bits; no items are in flight
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_dword_type_converter_top (
   input  wire logic  clock,
   input  wire logic  reset,
   sdtc_req_if.sink   req,
   sdtc_rsp_if.source rsp
);
   import sdtc_pkg::*;
   `include "signed_dword_type_converter_top_assert.svh"

   function automatic logic [7:0] split2(input logic [6:0] y);
      logic [13:0] p;
      logic [3:0]  t;
      logic [6:0]  u;
      p = 14'(y) * 14'd103;
      t = p[13:10];
      u = y - 7'(t * 7'd10);
      return {t, u[3:0]};
   endfunction

   function automatic logic [15:0] split4(input logic [13:0] x);
      logic [26:0] p;
      logic [6:0]  a;
      logic [13:0] b;
      p = 27'(x) * 27'd5243;
      a = p[25:19];
      b = x - 14'(a * 14'd100);
      return {split2(a), split2(b[6:0])};
   endfunction

   logic en;
   logic eno_ff, eno_in;
   logic accept;

   // stage 1
   logic              v1_ff;
   op_type            op1_ff;
   logic signed [31:0] val1_ff;
   logic              eno1_ff;
   // stage 2
   logic        v2_ff;
   op_type      op2_ff;
   logic        eno2_ff, sat2_ff;
   logic [63:0] res2_ff, res2_in;
   logic [26:0] mb2_ff;
   logic [13:0] hi2_ff;
   // stage 3
   logic        v3_ff;
   op_type      op3_ff;
   logic        eno3_ff, sat3_ff;
   logic [63:0] res3_ff;
   logic [13:0] hi3_ff, lo3_ff;
   // stage 4
   logic        v4_ff;
   logic        eno4_ff;
   logic [63:0] res4_ff, res4_in;

   flt_type     flt;
   logic [31:0] mag1;
   logic        sat2_in;
   logic [58:0] prod1;
   logic [26:0] lo_w;
   logic [31:0] digits;

   assign en     = !v4_ff || rsp.ready;
   assign req.ready = en;
   assign accept = req.valid && en;

   always_comb begin
      eno_in = eno_ff;
      if (op_type'(req.op) == OP_REAL) begin
         eno_in = !(req.value < -EXACT_LIMIT || req.value > EXACT_LIMIT);
      end
   end

   sdtc_float u_float (
      .value (val1_ff),
      .flt   (flt)
   );

   always_comb begin
      mag1  = val1_ff[31] ? 32'hFFFF_FFFF : val1_ff;
      prod1 = 59'(mag1[26:0]) * 59'(DIV10K_MUL);
      case (op1_ff)
         OP_BCD2: sat2_in = mag1 > BCD2_LIMIT;
         OP_BCD4: sat2_in = mag1 > BCD4_LIMIT;
         default: sat2_in = mag1 > BCD8_LIMIT;
      endcase
      case (op1_ff)
         OP_BOOL: res2_in = {63'd0, val1_ff != 32'sd0};
         OP_BYTE, OP_SINT, OP_USINT: res2_in = {56'd0, val1_ff[7:0]};
         OP_WORD, OP_INT, OP_UINT: res2_in = {48'd0, val1_ff[15:0]};
         OP_DWORD, OP_UDINT, OP_TIME: res2_in = {32'd0, val1_ff};
         OP_LINT: res2_in = {{32{val1_ff[31]}}, val1_ff};
         OP_REAL: res2_in = {32'd0, flt.single_bits};
         OP_LREAL: res2_in = flt.double_bits;
         default: res2_in = 64'd0;
      endcase
   end

   assign lo_w = mb2_ff - 27'(hi2_ff * 27'd10000);

   always_comb begin
      digits = {split4(hi3_ff), split4(lo3_ff)};
      case (op3_ff)
         OP_BCD2: res4_in = sat3_ff ? 64'h0FF : {56'd0, digits[7:0]};
         OP_BCD4: res4_in = sat3_ff ? 64'h0FFFF : {48'd0, digits[15:0]};
         OP_BCD8: res4_in = sat3_ff ? 64'h0FFFF_FFFF : {32'd0, digits};
         default: res4_in = res3_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eno_ff <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
      end else if (en) begin
         if (req.valid) begin
            eno_ff <= eno_in;
         end
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff  <= op_type'(req.op);
         val1_ff <= req.value;
         eno1_ff <= eno_in;
         op2_ff  <= op1_ff;
         eno2_ff <= eno1_ff;
         sat2_ff <= sat2_in;
         res2_ff <= res2_in;
         mb2_ff  <= mag1[26:0];
         hi2_ff  <= prod1[DIV10K_SHIFT+13:DIV10K_SHIFT];
         op3_ff  <= op2_ff;
         eno3_ff <= eno2_ff;
         sat3_ff <= sat2_ff;
         res3_ff <= res2_ff;
         hi3_ff  <= hi2_ff;
         lo3_ff  <= lo_w[13:0];
         eno4_ff <= eno3_ff;
         res4_ff <= res4_in;
      end
   end

   assign rsp.valid  = v4_ff;
   assign rsp.result = res4_ff;
   assign rsp.eno    = eno4_ff;

   `SDTC_ASSERT_NXT(a_real_clears, accept && req.op == OP_REAL && req.value > EXACT_LIMIT, !eno_ff)
   `SDTC_ASSERT_NXT(a_flag_holds, accept && req.op != OP_REAL, eno_ff == $past(eno_ff))
   `SDTC_ASSERT_NXT(a_stall_holds, v4_ff && !rsp.ready, v4_ff && $stable(res4_ff))
   `SDTC_ASSERT_NXT(a_pipe_moves, v1_ff && en, v2_ff)

endmodule

`default_nettype wire

FILE: hdl/sdtc_float.sv
// ---------------------------------------------------------------------------
// sdtc_float
// integer to single and double precision encoding, nearest even rounding
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdtc_float (
   input  wire logic signed [31:0] value,
   output sdtc_pkg::flt_type       flt
);
   import sdtc_pkg::*;

   logic        sign;
   logic [31:0] mag;
   logic [4:0]  top;
   logic [31:0] norm;
   logic [24:0] rnd;
   logic        round_up;
   logic [7:0]  exp_s;
   logic [10:0] exp_d;

   always_comb begin
      sign = value[31];
      mag  = sign ? (32'd0 - value) : value;
      top  = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) begin
            top = 5'(i);
         end
      end
      norm     = mag << (5'd31 - top);
      round_up = norm[7] & ((|norm[6:0]) | norm[8]);
      rnd      = {1'b0, norm[31:8]} + {24'd0, round_up};
      exp_s    = 8'(top) + 8'd127 + {7'd0, rnd[24]};
      exp_d    = 11'(top) + 11'd1023;
      if (mag == 32'd0) begin
         flt.single_bits = 32'd0;
         flt.double_bits = 64'd0;
      end else begin
         flt.single_bits = {sign, exp_s, rnd[24] ? 23'd0 : rnd[22:0]};
         flt.double_bits = {sign, exp_d, norm[30:0], 21'd0};
      end
   end

endmodule

`default_nettype wire
